[hw/rtl/ecrc_pkg.sv]
package ecrc_pkg;

    // Raw buffer depth; the address and count widths below follow from it.
    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam logic [7:0] CFG_START_BYTE  = 8'd0;
    localparam logic [7:0] CFG_END_BYTE    = 8'd1;
    localparam logic [7:0] CFG_ESCAPE_BYTE = 8'd2;
    localparam logic [7:0] CFG_ESCAPE_MASK = 8'd3;

    localparam logic [7:0] RST_START_BYTE  = 8'd126;
    localparam logic [7:0] RST_END_BYTE    = 8'd127;
    localparam logic [7:0] RST_ESCAPE_BYTE = 8'd125;
    localparam logic [7:0] RST_ESCAPE_MASK = 8'd32;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_DROP    = 2'd2;

    localparam logic [2:0] CAUSE_NONE         = 3'd0;
    localparam logic [2:0] CAUSE_NO_START     = 3'd1;
    localparam logic [2:0] CAUSE_MULTI_START  = 3'd2;
    localparam logic [2:0] CAUSE_DANGLING_ESC = 3'd3;
    localparam logic [2:0] CAUSE_TOO_SHORT    = 3'd4;
    localparam logic [2:0] CAUSE_BAD_CRC      = 3'd5;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] escape_byte;
        logic [7:0] escape_mask;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] frame_id;
        logic [7:0] payload_length;
        logic [7:0] data_byte;
        logic [2:0] drop_cause;
        logic       last;
    } res_t;

    // One byte of the reflected CRC-8, least significant bit first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc;
        d = data;
        for (int k = 0; k < 8; k++) begin
            mix = c[0] ^ d[0];
            c   = {1'b0, c[7:1]};
            if (mix) begin
                c = c ^ CRC_POLY;
            end
            d   = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

[hw/rtl/ecrc_walk.sv]
module ecrc_walk
    import ecrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       res_valid,
    input  logic       res_ready,
    output res_t       res
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SCAN_RD   = 3'd1;
    localparam logic [2:0] ST_SCAN_PROC = 3'd2;
    localparam logic [2:0] ST_DECIDE    = 3'd3;
    localparam logic [2:0] ST_EMIT_RD   = 3'd4;
    localparam logic [2:0] ST_EMIT_PROC = 3'd5;

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic [2:0]       state_reg,     state_next;
    logic [CNT_W-1:0] fill_reg,      fill_next;
    logic [CNT_W-1:0] lens_reg,      lens_next;
    logic [CNT_W-1:0] ptr_reg,       ptr_next;
    logic [CNT_W-1:0] start_pos_reg, start_pos_next;
    logic [CNT_W-1:0] n_reg,         n_next;
    logic [CNT_W-1:0] k_reg,         k_next;
    logic             found_reg,     found_next;
    logic             multi_reg,     multi_next;
    logic             esc_reg,       esc_next;
    logic [7:0]       crc_reg,       crc_next;
    logic [7:0]       prev_reg,      prev_next;
    logic [7:0]       id_reg,        id_next;

    logic [CNT_W-1:0] plen;
    logic             accept;
    logic             is_end;

    assign plen     = n_reg - CNT_W'(2);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign is_end   = (in_byte == cfg.end_byte);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= in_byte;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        lens_next      = lens_reg;
        ptr_next       = ptr_reg;
        start_pos_next = start_pos_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        found_next     = found_reg;
        multi_next     = multi_reg;
        esc_next       = esc_reg;
        crc_next       = crc_reg;
        prev_next      = prev_reg;
        id_next        = id_reg;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg[ADDR_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = fill_reg[ADDR_W-1:0];
        res_valid      = 1'b0;
        res            = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (is_end) begin
                        lens_next  = fill_reg;
                        fill_next  = '0;
                        ptr_next   = '0;
                        n_next     = '0;
                        found_next = 1'b0;
                        multi_next = 1'b0;
                        esc_next   = 1'b0;
                        crc_next   = '0;
                        state_next = ST_SCAN_RD;
                    end else begin
                        wr_en = 1'b1;
                        if (fill_reg == CNT_W'(BUFFER_DEPTH)) begin
                            wr_addr   = '0;
                            fill_next = CNT_W'(1);
                        end else begin
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_SCAN_RD: begin
                if (ptr_reg == lens_reg) begin
                    state_next = ST_DECIDE;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_SCAN_PROC;
                end
            end
            ST_SCAN_PROC: begin
                // Any start byte after the first one spoils the frame, escaped or not.
                if (!found_reg) begin
                    if (rd_data_reg == cfg.start_byte) begin
                        found_next     = 1'b1;
                        start_pos_next = ptr_reg;
                    end
                end else if (rd_data_reg == cfg.start_byte) begin
                    multi_next = 1'b1;
                end else if (!esc_reg && rd_data_reg == cfg.escape_byte) begin
                    esc_next = 1'b1;
                end else begin
                    esc_next  = 1'b0;
                    prev_next = esc_reg ? (rd_data_reg ^ cfg.escape_mask) : rd_data_reg;
                    n_next    = n_reg + CNT_W'(1);
                    if (n_reg == '0) begin
                        id_next = prev_next;
                    end else begin
                        crc_next = crc8_step(crc_reg, prev_reg);
                    end
                end
                ptr_next   = ptr_reg + CNT_W'(1);
                state_next = ST_SCAN_RD;
            end
            ST_DECIDE: begin
                res_valid = 1'b1;
                res.kind  = KIND_DROP;
                res.last  = 1'b1;
                if (!found_reg) begin
                    res.drop_cause = CAUSE_NO_START;
                end else if (multi_reg) begin
                    res.drop_cause = CAUSE_MULTI_START;
                end else if (esc_reg) begin
                    res.drop_cause = CAUSE_DANGLING_ESC;
                end else if (n_reg < CNT_W'(2)) begin
                    res.drop_cause = CAUSE_TOO_SHORT;
                end else if (crc_reg != prev_reg) begin
                    res.drop_cause = CAUSE_BAD_CRC;
                end else begin
                    res.kind           = KIND_HEADER;
                    res.drop_cause     = CAUSE_NONE;
                    res.frame_id       = id_reg;
                    res.payload_length = 8'(plen);
                    res.last           = (plen == '0);
                end
                if (res_ready) begin
                    if (res.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next   = start_pos_reg + CNT_W'(1);
                        k_next     = '0;
                        esc_next   = 1'b0;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_EMIT_RD: begin
                rd_en      = 1'b1;
                state_next = ST_EMIT_PROC;
            end
            ST_EMIT_PROC: begin
                if (!esc_reg && rd_data_reg == cfg.escape_byte) begin
                    esc_next   = 1'b1;
                    ptr_next   = ptr_reg + CNT_W'(1);
                    state_next = ST_EMIT_RD;
                end else if (k_reg == '0) begin
                    // The first body byte is the id, already reported in the header.
                    esc_next   = 1'b0;
                    k_next     = CNT_W'(1);
                    ptr_next   = ptr_reg + CNT_W'(1);
                    state_next = ST_EMIT_RD;
                end else begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_PAYLOAD;
                    res.frame_id   = id_reg;
                    res.data_byte  = esc_reg ? (rd_data_reg ^ cfg.escape_mask) : rd_data_reg;
                    res.last       = (k_reg == plen);
                    if (res_ready) begin
                        esc_next   = 1'b0;
                        k_next     = k_reg + CNT_W'(1);
                        ptr_next   = ptr_reg + CNT_W'(1);
                        state_next = res.last ? ST_IDLE : ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
        lens_reg      <= lens_next;
        ptr_reg       <= ptr_next;
        start_pos_reg <= start_pos_next;
        n_reg         <= n_next;
        k_reg         <= k_next;
        found_reg     <= found_next;
        multi_reg     <= multi_next;
        esc_reg       <= esc_next;
        crc_reg       <= crc_next;
        prev_reg      <= prev_next;
        id_reg        <= id_next;
    end

    a_end_clears_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_end |=> fill_reg == '0)
        else $error("fill count not cleared by end of frame");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(BUFFER_DEPTH))
        else $error("fill count beyond buffer depth");

    a_last_ends_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_ready && res.last |=> state_reg == ST_IDLE)
        else $error("walk continued after final result");

    a_no_result_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !in_ready)
        else $error("result offered while taking input bytes");

endmodule

[hw/rtl/escaped_frame_rx_crc8_check.sv]
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_rx_byte
// m_        out        m_valid / m_ready    m_kind, m_frame_id, m_payload_length,
//                                           m_data_byte, m_drop_cause, m_last
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A byte other than the end delimiter is written into the buffer memory when it is accepted.
// An end delimiter over the buffered bytes starts a check of the frame through the single read
// port of the buffer memory, a read state and a process state per buffered byte, then a walk
// from the id to the last payload byte, escapes included; a stalled result channel holds it.
// Reset (aresetn low, synchronous) restores the delimiter and escape registers and empties the buffer.
// The output register lets the next byte be taken while the final result still waits.
module escaped_frame_rx_crc8_check
    import ecrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_frame_id,
    output logic [7:0] m_payload_length,
    output logic [7:0] m_data_byte,
    output logic [2:0] m_drop_cause,
    output logic       m_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    res_t res;
    res_t out_reg;
    logic res_valid;
    logic res_ready;
    logic m_valid_reg, m_valid_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_START_BYTE:  cfg_next.start_byte  = cfg_data;
                CFG_END_BYTE:    cfg_next.end_byte    = cfg_data;
                CFG_ESCAPE_BYTE: cfg_next.escape_byte = cfg_data;
                CFG_ESCAPE_MASK: cfg_next.escape_mask = cfg_data;
                default: begin
                end
            endcase
        end
    end

    ecrc_walk u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_byte   (s_rx_byte),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // A new result may enter when the register is empty or its transfer completes now.
    assign res_ready    = !m_valid_reg || m_ready;
    assign m_valid_next = res_valid || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte  <= RST_START_BYTE;
            cfg_reg.end_byte    <= RST_END_BYTE;
            cfg_reg.escape_byte <= RST_ESCAPE_BYTE;
            cfg_reg.escape_mask <= RST_ESCAPE_MASK;
            m_valid_reg         <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = out_reg.kind;
    assign m_frame_id       = out_reg.frame_id;
    assign m_payload_length = out_reg.payload_length;
    assign m_data_byte      = out_reg.data_byte;
    assign m_drop_cause     = out_reg.drop_cause;
    assign m_last           = out_reg.last;

endmodule
